// ----- src/mcpwc_pkg.sv -----
// shared types and constants for the multi-channel pulse width capture block
// used by mcpwc_ctrl, mcpwc_dp and multi_channel_pulse_width_capture
package mcpwc_pkg;

	// channel count, 1 to 16; the channel field is always 4 bits wide
	localparam int NUM_CHANNELS = 16;
	localparam int MAX_CHANNELS = 16;
	localparam int CH_W         = 4;

	localparam int LEVELS_W = 16;
	localparam int TIME_W   = 16;
	localparam int PULSE_W  = 15;

	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 24;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_ADDR_W-1:0] REG_LO_BOUND = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_HI_BOUND = 1'b1;

	localparam logic [PULSE_W-1:0] LO_BOUND_RESET = 15'd900;
	localparam logic [PULSE_W-1:0] HI_BOUND_RESET = 15'd2100;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_event;
		logic step;
		logic capture;
		logic write_ts;
		logic push;
		logic push_last;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic hit;
		logic miss;
		logic pend_valid;
		logic out_free;
		logic ch_last;
	} status_t;

endpackage

// ----- src/mcpwc_dp.sv -----
// datapath: config registers, level and timestamp state, channel walker,
// pending capture and output register; depends on mcpwc_pkg
module mcpwc_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mcpwc_pkg::cmd_t                        cmd,
	output mcpwc_pkg::status_t                     status,
	input  logic [mcpwc_pkg::S_DATA_W-1:0]         s_tdata,
	input  logic                                   cfg_we,
	input  logic [mcpwc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [mcpwc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [mcpwc_pkg::M_DATA_W-1:0]         m_tdata,
	output logic                                   m_tlast
);

	logic [mcpwc_pkg::PULSE_W-1:0]  lo_bound_q;
	logic [mcpwc_pkg::PULSE_W-1:0]  hi_bound_q;
	logic [mcpwc_pkg::LEVELS_W-1:0] prev_levels_q;
	logic [mcpwc_pkg::LEVELS_W-1:0] toggled_q;
	logic [mcpwc_pkg::TIME_W-1:0]   now_q;
	logic [mcpwc_pkg::CH_W-1:0]     ch_q;
	logic [mcpwc_pkg::TIME_W-1:0]   ts_q [mcpwc_pkg::MAX_CHANNELS];

	logic                           pend_valid_q;
	logic [mcpwc_pkg::CH_W-1:0]     pend_ch_q;
	logic [mcpwc_pkg::PULSE_W-1:0]  pend_width_q;

	logic                           out_valid_q;
	logic [mcpwc_pkg::CH_W-1:0]     out_ch_q;
	logic [mcpwc_pkg::PULSE_W-1:0]  out_width_q;
	logic                           out_last_q;

	logic [mcpwc_pkg::LEVELS_W-1:0] in_levels;
	logic [mcpwc_pkg::TIME_W-1:0]   in_time;
	logic [mcpwc_pkg::TIME_W-1:0]   elapsed;
	logic                           toggled_bit;
	logic                           in_window;

	assign in_levels = s_tdata[mcpwc_pkg::LEVELS_W-1:0];
	assign in_time   = s_tdata[mcpwc_pkg::LEVELS_W +: mcpwc_pkg::TIME_W];

	// wrapped difference; a set sign bit means negative and never fits
	assign elapsed     = now_q - ts_q[ch_q];
	assign toggled_bit = toggled_q[ch_q];
	assign in_window   = !elapsed[mcpwc_pkg::TIME_W-1]
		&& (elapsed[mcpwc_pkg::PULSE_W-1:0] > lo_bound_q)
		&& (elapsed[mcpwc_pkg::PULSE_W-1:0] < hi_bound_q);

	always_comb begin
		status.hit        = toggled_bit && in_window;
		status.miss       = toggled_bit && !in_window;
		status.pend_valid = pend_valid_q;
		status.out_free   = !out_valid_q || m_tready;
		status.ch_last    = (ch_q == mcpwc_pkg::LAST_CH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_bound_q <= mcpwc_pkg::LO_BOUND_RESET;
			hi_bound_q <= mcpwc_pkg::HI_BOUND_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mcpwc_pkg::REG_LO_BOUND: lo_bound_q <= cfg_wdata;
				mcpwc_pkg::REG_HI_BOUND: hi_bound_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// event capture and channel walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_levels_q <= '0;
			toggled_q     <= '0;
			now_q         <= '0;
			ch_q          <= '0;
		end else if (cmd.load_event) begin
			prev_levels_q <= in_levels;
			toggled_q     <= in_levels ^ prev_levels_q;
			now_q         <= in_time;
			ch_q          <= '0;
		end else if (cmd.step) begin
			ch_q <= ch_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcpwc_pkg::MAX_CHANNELS; i++) begin
				ts_q[i] <= '0;
			end
		end else if (cmd.write_ts) begin
			ts_q[ch_q] <= now_q;
		end
	end

	// pending capture: held until we know whether it is the last of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (cmd.capture) begin
			pend_valid_q <= 1'b1;
		end else if (cmd.push) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pend_ch_q    <= ch_q;
			pend_width_q <= elapsed[mcpwc_pkg::PULSE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_ch_q    <= pend_ch_q;
			out_width_q <= pend_width_q;
			out_last_q  <= cmd.push_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(mcpwc_pkg::M_DATA_W - mcpwc_pkg::CH_W - mcpwc_pkg::PULSE_W){1'b0}},
		out_width_q, out_ch_q};
	assign m_tlast  = out_last_q;

	// a push moves a real pending capture
	a_push_has_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> pend_valid_q)
		else $error("push without pending capture");

	// a waiting result is never overwritten
	a_push_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid_q || m_tready))
		else $error("output register overwritten");

	// a new capture never drops an older one that is still pending
	a_capture_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.capture && pend_valid_q) |-> cmd.push)
		else $error("pending capture dropped");

endmodule

// ----- src/mcpwc_ctrl.sv -----
// controller state machine: idle, channel scan and final flush
// depends on mcpwc_pkg; drives the datapath through cmd_t
module mcpwc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  mcpwc_pkg::status_t status,
	output mcpwc_pkg::cmd_t    cmd
);

	mcpwc_pkg::state_t state_q;
	mcpwc_pkg::state_t state_d;
	logic              stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcpwc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a second capture must wait while the pending one cannot move out
	assign stall = status.hit && status.pend_valid && !status.out_free;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			mcpwc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_event = 1'b1;
					state_d        = mcpwc_pkg::ST_SCAN;
				end
			end
			mcpwc_pkg::ST_SCAN: begin
				if (!stall) begin
					cmd.step     = 1'b1;
					cmd.capture  = status.hit;
					cmd.push     = status.hit && status.pend_valid;
					cmd.write_ts = status.miss;
					if (status.ch_last) begin
						state_d = mcpwc_pkg::ST_FLUSH;
					end
				end
			end
			mcpwc_pkg::ST_FLUSH: begin
				if (!status.pend_valid) begin
					state_d = mcpwc_pkg::ST_IDLE;
				end else if (status.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = mcpwc_pkg::ST_IDLE;
				end
			end
			default: state_d = mcpwc_pkg::ST_IDLE;
		endcase
	end

	// nothing is left pending between events
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mcpwc_pkg::ST_IDLE) |-> !status.pend_valid)
		else $error("pending capture left in idle");

	// an accepted event always starts a scan
	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == mcpwc_pkg::ST_SCAN))
		else $error("accepted event did not start a scan");

endmodule

// ----- src/multi_channel_pulse_width_capture.sv -----
// top level of the multi-channel pulse width capture block
// depends on mcpwc_pkg, mcpwc_ctrl and mcpwc_dp
//
//   channel   direction  width  contents (low bit first)
//   s_t*      in         32     pin_levels[15:0], time_us[31:16]
//   m_t*      out        24     channel[3:0], width_us[18:4], zero[23:19]; tlast = last_of_run
//   cfg_*     in         15     index 0 lower width bound, index 1 upper width bound
//
// each event runs a load step, a walk through the channels one at a time via
// the single timestamp compare, and a flush step that releases any held
// capture with tlast set
// a stalled output holds the channel walk only when a second capture is
// found while the previous one still waits; untoggled channels never stall
// the flush cycle waits for the output the same way
// reset clears all timestamps and previous levels and loads the default bounds
// the next event is taken while the last result still waits in the output
module multi_channel_pulse_width_capture (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mcpwc_pkg::S_DATA_W-1:0]       s_tdata,   // pin_levels, time_us
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mcpwc_pkg::M_DATA_W-1:0]       m_tdata,   // channel, width_us, pad
	output logic                                 m_tlast,
	input  logic                                 cfg_we,
	input  logic [mcpwc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [mcpwc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	mcpwc_pkg::cmd_t    cmd;
	mcpwc_pkg::status_t status;

	// sequencing: idle / scan / flush
	mcpwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// state, compare against the window and result registers
	mcpwc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- test/multi_channel_pulse_width_capture_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for multi_channel_pulse_width_capture: directed, boundary,
// back-pressure and random pin-change requests checked against an in-bench predictor
// depends on mcpwc_pkg and the block's rtl
module multi_channel_pulse_width_capture_tb;

	localparam int CH_W       = mcpwc_pkg::CH_W;
	localparam int LEVELS_W   = mcpwc_pkg::LEVELS_W;
	localparam int TIME_W     = mcpwc_pkg::TIME_W;
	localparam int PULSE_W    = mcpwc_pkg::PULSE_W;
	localparam int S_DATA_W   = mcpwc_pkg::S_DATA_W;
	localparam int M_DATA_W   = mcpwc_pkg::M_DATA_W;
	localparam int CFG_ADDR_W = mcpwc_pkg::CFG_ADDR_W;
	localparam int CFG_DATA_W = mcpwc_pkg::CFG_DATA_W;

	localparam int HALF_PERIOD     = 6;
	// a request that yields no capture can still be in the channel walk when the
	// last expected capture arrives, so give it a couple of full walks to finish
	localparam int SETTLE_CYCLES   = 2 * (mcpwc_pkg::NUM_CHANNELS + 2) + 4;
	localparam int DRAIN_LIMIT     = 200000;
	localparam int RANDOM_REQUESTS = 500;
	localparam int RANDOM_PHASES   = 5;
	localparam int LONG_STALL      = 300;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic [PULSE_W-1:0] width_us;
		logic               last_of_run;
	} capture_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;   // pin_levels[15:0], time_us[31:16]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;   // channel[3:0], width_us[18:4], zero[23:19]
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// predictor copy of the block state and bounds
	logic [LEVELS_W-1:0] prior_levels;
	logic [TIME_W-1:0]   channel_stamps [mcpwc_pkg::MAX_CHANNELS];
	logic [PULSE_W-1:0]  window_lo;
	logic [PULSE_W-1:0]  window_hi;
	capture_t            expected_captures [$];

	logic [TIME_W-1:0] clock_us;
	capture_t          head_capture;
	int                requests_sent   = 0;
	int                captures_seen   = 0;
	int                register_writes = 0;
	int                error_count     = 0;
	int                stall_request   = 0;
	bit                quiet           = 1'b0;

	multi_channel_pulse_width_capture i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	function automatic void reset_predictor();
		window_lo    = mcpwc_pkg::LO_BOUND_RESET;
		window_hi    = mcpwc_pkg::HI_BOUND_RESET;
		prior_levels = '0;
		clock_us     = '0;
		for (int ch = 0; ch < mcpwc_pkg::MAX_CHANNELS; ch++)
			channel_stamps[ch] = '0;
	endfunction

	// walk the toggled channels in order; a width strictly inside the window is
	// captured and the stamp kept, anything else restarts the channel's stamp
	function automatic void predict_captures(input logic [LEVELS_W-1:0] levels,
			input logic [TIME_W-1:0] stamp);
		logic [LEVELS_W-1:0] toggled;
		logic [TIME_W-1:0]   diff;
		int                  elapsed;
		capture_t            held;
		bit                  have_held;
		toggled      = levels ^ prior_levels;
		prior_levels = levels;
		have_held    = 1'b0;
		for (int ch = 0; ch < mcpwc_pkg::NUM_CHANNELS; ch++) begin
			if (toggled[ch]) begin
				diff    = stamp - channel_stamps[ch];
				elapsed = int'($signed(diff));
				if (elapsed > int'(window_lo) && elapsed < int'(window_hi)) begin
					if (have_held)
						expected_captures.push_back(held);
					held.channel     = CH_W'(ch);
					held.width_us    = diff[PULSE_W-1:0];
					held.last_of_run = 1'b0;
					have_held        = 1'b1;
				end else begin
					channel_stamps[ch] = stamp;
				end
			end
		end
		// only the final capture of a request carries tlast
		if (have_held) begin
			held.last_of_run = 1'b1;
			expected_captures.push_back(held);
		end
	endfunction

	// one request; an optional idle burst first, then hold tvalid until taken
	task automatic send_request(input logic [LEVELS_W-1:0] levels,
			input logic [TIME_W-1:0] stamp);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {stamp, levels};
		do @(posedge clk); while (!s_tready);
		predict_captures(levels, stamp);
		clock_us = stamp;
		requests_sent++;
	endtask

	// sender goes quiet, then all captures drain and the channel walk settles
	task automatic wait_for_idle();
		int waited;
		@(negedge clk);
		s_tvalid = 1'b0;
		waited   = 0;
		while (expected_captures.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_ADDR_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = index;
		cfg_wdata = value;
		@(posedge clk);
		if (index == mcpwc_pkg::REG_LO_BOUND)
			window_lo = value;
		else
			window_hi = value;
		register_writes++;
	endtask

	task automatic set_window(input int lo, input int hi);
		wait_for_idle();
		write_register(mcpwc_pkg::REG_LO_BOUND, CFG_DATA_W'(lo));
		write_register(mcpwc_pkg::REG_HI_BOUND, CFG_DATA_W'(hi));
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// mostly a width inside the current window, sometimes on a bound or anywhere
	function automatic int pick_width();
		if (int'(window_hi) > int'(window_lo) + 1 && $urandom_range(0, 7) != 0)
			return $urandom_range(int'(window_lo) + 1, int'(window_hi) - 1);
		case ($urandom_range(0, 2))
			0: return int'(window_lo);
			1: return int'(window_hi);
			default: return $urandom_range(0, 32767);
		endcase
	endfunction

	// one servo-style frame: leading edges on a set of channels, then trailing
	// edges in time order; channels that share a width fall in one request
	task automatic send_pulse_frame();
		logic [LEVELS_W-1:0] mask;
		logic [LEVELS_W-1:0] remaining;
		logic [LEVELS_W-1:0] group;
		logic [TIME_W-1:0]   start;
		int                  widths [mcpwc_pkg::MAX_CHANNELS];
		int                  slots [4];
		int                  shortest;
		mask = LEVELS_W'($urandom_range(1, 16'hFFFF));
		if ($urandom_range(0, 1) == 0 && (mask & LEVELS_W'($urandom())) != 0)
			mask = mask & LEVELS_W'($urandom());
		start = clock_us + TIME_W'($urandom_range(2500, 20000));
		for (int s = 0; s < 4; s++)
			slots[s] = pick_width();
		for (int ch = 0; ch < mcpwc_pkg::MAX_CHANNELS; ch++)
			widths[ch] = ($urandom_range(0, 1) != 0) ? slots[$urandom_range(0, 3)] : pick_width();
		send_request(prior_levels ^ mask, start);
		remaining = mask;
		// a broken frame loses some of its trailing edges
		if ($urandom_range(0, 9) == 0)
			remaining = remaining & LEVELS_W'($urandom());
		while (remaining != 0) begin
			shortest = 32'h7FFF_FFFF;
			for (int ch = 0; ch < mcpwc_pkg::MAX_CHANNELS; ch++)
				if (remaining[ch] && widths[ch] < shortest)
					shortest = widths[ch];
			group = '0;
			for (int ch = 0; ch < mcpwc_pkg::MAX_CHANNELS; ch++)
				if (remaining[ch] && widths[ch] == shortest)
					group[ch] = 1'b1;
			send_request(prior_levels ^ group, start + TIME_W'(shortest));
			remaining = remaining & ~group;
		end
	endtask

	// reset bounds 900 / 2100 are in force, nothing has been written yet
	task automatic test_directed();
		send_request(16'hFFFF, 16'd1000);    // every channel captured in one request
		send_request(16'h0000, 16'h0100);    // every channel too short, stamps restart
		send_request(16'h0001, 16'd1156);    // width equal to the lower bound
		send_request(16'h0003, 16'd1157);    // just above the lower bound
		send_request(16'h0007, 16'd2355);    // just below the upper bound
		send_request(16'h000F, 16'd2356);    // width equal to the upper bound
		send_request(16'h000F, 16'd5000);    // no toggles at all
		send_request(16'h0007, 16'd1356);    // time went backwards
		send_request(16'h0017, 16'hFF00);    // large gap reads as negative
		send_request(16'h0007, 16'h0300);    // capture across the timer wrap
		send_request(16'h8007, 16'hFFFF);    // top channel, top of the timer
		send_request(16'h0007, 16'd1200);    // top channel captured across the wrap
		send_request(16'hFFF8, 16'h0000);    // all channels toggle, all restart at zero
		send_request(16'h0000, 16'd1000);    // most channels captured together
		send_request(16'h5555, 16'd1950);    // alternate channels
	endtask

	// sink holds off long enough for the block to fill and stall its input
	task automatic test_back_pressure();
		logic [TIME_W-1:0] start;
		stall_request = LONG_STALL;
		for (int p = 0; p < 4; p++) begin
			start = clock_us + TIME_W'(5000);
			send_request(~prior_levels, start);
			send_request(~prior_levels, start + TIME_W'(1500));
		end
		// sender pauses until the stalled captures have all drained
		wait_for_idle();
	endtask

	// probe each bound setting on a single channel right at and next to the bounds
	task automatic test_register_bounds();
		int                lows [5];
		int                highs [5];
		int                offsets [4];
		logic [CH_W-1:0]   ch;
		lows  = '{0, 32767, 100, 100, 32767};
		highs = '{32767, 0, 101, 102, 32767};
		for (int k = 0; k < 5; k++) begin
			set_window(lows[k], highs[k]);
			offsets = '{lows[k], lows[k] + 1, highs[k] - 1, highs[k]};
			ch      = CH_W'(3 * k);
			for (int j = 0; j < 4; j++)
				send_request(prior_levels ^ (LEVELS_W'(1) << ch),
					channel_stamps[ch] + TIME_W'(offsets[j]));
		end
	endtask

	// mostly well-formed frames with random widths, the rest random noise
	task automatic test_random_traffic();
		int target;
		int lo;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: set_window(int'(mcpwc_pkg::LO_BOUND_RESET), int'(mcpwc_pkg::HI_BOUND_RESET));
				1: begin
					lo = $urandom_range(0, 3000);
					set_window(lo, lo + $urandom_range(2, 5000));
				end
				2: set_window($urandom_range(0, 32767), $urandom_range(0, 32767));
				3: set_window(0, 32767);
				default: set_window(1000, 2000);
			endcase
			// the closing phase runs with no idling on either side
			quiet  = (phase == RANDOM_PHASES - 1);
			target = requests_sent + RANDOM_REQUESTS / RANDOM_PHASES;
			while (requests_sent < target) begin
				if ($urandom_range(0, 4) != 0)
					send_pulse_frame();
				else
					send_request(LEVELS_W'($urandom()), ($urandom_range(0, 1) != 0) ?
						clock_us + TIME_W'($urandom_range(0, 3000)) : TIME_W'($urandom()));
			end
		end
	endtask

	// receiver: random stall bursts, or a long hold when one is asked for
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (stall_request > 0) begin
				m_tready = 1'b0;
				repeat (stall_request) @(negedge clk);
				stall_request = 0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end else begin
				m_tready = 1'b1;
				@(negedge clk);
			end
		end
	end

	// every accepted capture against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			captures_seen++;
			if (expected_captures.size() == 0) begin
				$error("capture with nothing expected: channel %0d width_us %0d",
					m_tdata[3:0], m_tdata[18:4]);
				error_count++;
			end else begin
				head_capture = expected_captures.pop_front();
				if (m_tdata[3:0] !== head_capture.channel) begin
					$error("channel: expected %0d, got %0d", head_capture.channel, m_tdata[3:0]);
					error_count++;
				end
				if (m_tdata[18:4] !== head_capture.width_us) begin
					$error("width_us: expected %0d, got %0d", head_capture.width_us,
						m_tdata[18:4]);
					error_count++;
				end
				if (m_tlast !== head_capture.last_of_run) begin
					$error("last_of_run: expected %0d, got %0d", head_capture.last_of_run,
						m_tlast);
					error_count++;
				end
				if (m_tdata[23:19] !== 5'd0) begin
					$error("pad: expected 0, got %0d", m_tdata[23:19]);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		reset_predictor();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		wait_for_idle();
		test_back_pressure();
		test_register_bounds();
		test_random_traffic();
		wait_for_idle();

		if (expected_captures.size() != 0) begin
			$error("%0d expected captures never arrived, next channel %0d width_us %0d",
				expected_captures.size(), expected_captures[0].channel,
				expected_captures[0].width_us);
			error_count++;
		end
		$display("covered %0d pin-change requests and %0d captures over %0d bound writes,",
			requests_sent, captures_seen, register_writes);
		$display("including bound edges, timer wrap, empty windows and a long output stall");
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// generous watchdog, several times the slowest legal run
	initial begin
		#(6_000_000);
		$display("Some tests failed");
		$finish;
	end

endmodule
